/* sv/pte_pkg.sv */
`default_nettype none

package pte_pkg;

    // command codes
    localparam logic [1:0] CMD_MODULE = 2'd0;
    localparam logic [1:0] CMD_TRACK  = 2'd1;
    localparam logic [1:0] CMD_EVENT  = 2'd2;

    // status codes
    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_REPEAT0 = 3'd2;
    localparam logic [2:0] ST_DROPPED = 3'd3;
    localparam logic [2:0] ST_CONTROL = 3'd4;

    // event codes
    localparam logic [7:0] CODE_COPY     = 8'h7F;
    localparam logic [7:0] CODE_SAMPLE   = 8'h80;
    localparam logic [7:0] CODE_FX_FIRST = 8'h81;
    localparam logic [7:0] CODE_FX_LAST  = 8'h96;
    localparam logic [7:0] CODE_PAN      = 8'h97;
    localparam logic [7:0] PARAM_SURR    = 8'hA4;
    // code minus this gives the feature bit of a known effect
    localparam logic [7:0] FX_BIT_OFFSET = 8'h7B;

    // row flag bits
    localparam logic [5:0] FLAG_NOTE   = 6'h10;
    localparam logic [5:0] FLAG_SAMPLE = 6'h20;
    localparam logic [5:0] FLAG_COUNT  = 6'h0F;

    // feature bits
    localparam int FEAT_W       = 30;
    localparam int FEAT_REPEAT0 = 0;
    localparam int FEAT_FX2     = 1;
    localparam int FEAT_FX3     = 2;
    localparam int FEAT_FX4     = 3;
    localparam int FEAT_FXMORE  = 4;
    localparam int FEAT_UNKNOWN = 5;
    localparam int FEAT_PAN     = 28;
    localparam int FEAT_SURR    = 29;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // 29-bit row head, sample in the top bits
    typedef struct packed {
        logic [7:0] sample;
        logic [7:0] volume;
        logic [6:0] note;
        logic [5:0] flags;
    } head_t;

    localparam int HEAD_W = $bits(head_t);

    // sticky features plus the single effect-count bit
    function automatic logic [FEAT_W-1:0] feature_view(
        input logic [FEAT_W-1:0] used,
        input logic [2:0]        max_cnt
    );
        logic [FEAT_W-1:0] m;
        m = used;
        case (max_cnt)
            3'd0, 3'd1: ;
            3'd2:    m[FEAT_FX2]    = 1'b1;
            3'd3:    m[FEAT_FX3]    = 1'b1;
            3'd4:    m[FEAT_FX4]    = 1'b1;
            default: m[FEAT_FXMORE] = 1'b1;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* sv/pte_evt_if.sv */
`default_nettype none

interface pte_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] row;
    logic [7:0] code;
    logic [7:0] param;

    modport source (output valid, output command, output row, output code, output param,
                    input ready);
    modport sink   (input valid, input command, input row, input code, input param,
                    output ready);
endinterface

`default_nettype wire

/* sv/pte_res_if.sv */
`default_nettype none

interface pte_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  row_out;
    logic [6:0]  note;
    logic [7:0]  volume;
    logic [7:0]  sample;
    logic [5:0]  event_flags;
    logic [63:0] effects;
    logic [5:0]  track_flags;
    logic [29:0] feature_mask;
    logic [2:0]  highest_effects;

    modport source (output valid, output status, output row_out, output note, output volume,
                    output sample, output event_flags, output effects, output track_flags,
                    output feature_mask, output highest_effects, input ready);
    modport sink   (input valid, input status, input row_out, input note, input volume,
                    input sample, input event_flags, input effects, input track_flags,
                    input feature_mask, input highest_effects, output ready);
endinterface

`default_nettype wire

/* sv/pte_ram.sv */
`default_nettype none

module pte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/packed_track_event_expander.sv */
`default_nettype none
// packed track event expander
// result: registered when the exec state fires after its beat is accepted, later while the previous result is held
// pacing: a new beat is taken only back in idle, after the read-then-write pass over the row rams
// reset: all control state, track flags, feature mask and effect high mark clear at once
// row store: per-row valid flags clear together, so there is no clearing sweep

module packed_track_event_expander
    import pte_pkg::*;
#(
    parameter int ROWS         = 64,
    parameter int EFFECT_SLOTS = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pte_evt_if.sink   evt,
    pte_res_if.source res
);

    localparam int RW   = $clog2(ROWS);
    localparam int FX_W = EFFECT_SLOTS * 16;

    // control and sticky state
    state_t            state_reg, state_next;
    logic [ROWS-1:0]   valid_reg, valid_next;
    logic              rd_valid_reg;
    logic [5:0]        track_reg, track_next;
    logic              ended_reg, ended_next;
    logic [FEAT_W-1:0] used_reg, used_next;
    logic [2:0]        max_reg, max_next;

    // captured beat
    logic [1:0] cmd_reg;
    logic [7:0] row_reg;
    logic [7:0] code_reg;
    logic [7:0] param_reg;

    // result register
    logic              res_valid_reg, res_valid_next;
    logic [2:0]        status_reg;
    logic [5:0]        row_out_reg;
    head_t             head_out_reg;
    logic [63:0]       fx_out_reg;
    logic [5:0]        track_out_reg;
    logic [FEAT_W-1:0] feat_out_reg;
    logic [2:0]        max_out_reg;

    // handshake
    logic accept;
    logic fire;

    // ram ports
    logic [RW-1:0]     rd_addr;
    logic [HEAD_W-1:0] head_rdata;
    logic [FX_W-1:0]   fx_rdata;
    logic              wr_en;
    head_t             head_new;
    logic [FX_W-1:0]   fx_new;

    // exec stage datapath
    head_t           rd_head;
    logic [FX_W-1:0] rd_fx;
    logic            row_ok;
    logic [3:0]      cnt;
    logic [4:0]      fx_bit;
    logic [2:0]      status_n;
    logic            show;
    logic            clr_track;
    head_t           head_show;
    logic [FX_W-1:0] fx_show;

    // ---------------------------------------------------------------
    // state machine: idle takes a beat and starts the ram read, exec modifies the row and writes back
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        evt.ready = 1'b0;
        fire      = 1'b0;
        unique case (state_reg)
            S_IDLE:  evt.ready = 1'b1;
            S_EXEC:  fire      = !res_valid_reg || res.ready;
            default: ;
        endcase
    end

    assign accept = evt.valid && evt.ready;

    // copy past row zero reads the row above, every other case reads the target row
    always_comb
    begin
        rd_addr = evt.row[RW-1:0];
        if (evt.code == CODE_COPY && evt.row != 8'd0)
        begin
            rd_addr = RW'(evt.row - 8'd1);
        end
    end

    pte_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (ROWS)
    ) u_head_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (row_reg[RW-1:0]),
        .wdata (head_new),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (head_rdata)
    );

    pte_ram #(
        .WIDTH (FX_W),
        .DEPTH (ROWS)
    ) u_fx_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (row_reg[RW-1:0]),
        .wdata (fx_new),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (fx_rdata)
    );

    // ---------------------------------------------------------------
    // read-modify-write of the row, sticky state updates
    // ---------------------------------------------------------------
    always_comb
    begin
        rd_head   = rd_valid_reg ? head_t'(head_rdata) : '0;
        rd_fx     = rd_valid_reg ? fx_rdata : '0;
        row_ok    = !ended_reg && ({1'b0, row_reg} < 9'(ROWS));
        cnt       = rd_head.flags[3:0];
        fx_bit    = 5'(code_reg - FX_BIT_OFFSET);

        head_new  = rd_head;
        fx_new    = rd_fx;
        wr_en     = 1'b0;
        status_n  = ST_CONTROL;
        show      = 1'b0;
        clr_track = 1'b0;
        used_next = used_reg;
        max_next  = max_reg;
        ended_next = ended_reg;

        case (cmd_reg)
            CMD_MODULE:
            begin
                clr_track = 1'b1;
                used_next = '0;
                max_next  = '0;
            end
            CMD_TRACK:
            begin
                clr_track = 1'b1;
            end
            CMD_EVENT:
            begin
                if (!row_ok)
                begin
                    ended_next = 1'b1;
                    status_n   = ST_IGNORED;
                end
                else if (code_reg < CODE_COPY)
                begin
                    head_new.flags  = rd_head.flags | FLAG_NOTE;
                    head_new.note   = code_reg[6:0];
                    head_new.volume = param_reg;
                    wr_en    = 1'b1;
                    status_n = ST_STORED;
                    show     = 1'b1;
                end
                else if (code_reg == CODE_COPY)
                begin
                    show = 1'b1;
                    if (row_reg == 8'd0)
                    begin
                        // repeat at row zero: nothing stored
                        used_next[FEAT_REPEAT0] = 1'b1;
                        status_n = ST_REPEAT0;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        status_n = ST_STORED;
                    end
                end
                else if (code_reg == CODE_SAMPLE)
                begin
                    head_new.flags  = rd_head.flags | FLAG_SAMPLE;
                    head_new.sample = param_reg;
                    wr_en    = 1'b1;
                    status_n = ST_STORED;
                    show     = 1'b1;
                end
                else
                begin
                    show = 1'b1;
                    if ({1'b0, cnt} + 5'd1 > {2'b00, max_reg})
                    begin
                        max_next = 3'(cnt + 4'd1);
                    end
                    if (32'(cnt) >= EFFECT_SLOTS)
                    begin
                        status_n = ST_DROPPED;
                    end
                    else
                    begin
                        if (code_reg <= CODE_FX_LAST)
                        begin
                            used_next[fx_bit] = 1'b1;
                        end
                        else if (code_reg == CODE_PAN)
                        begin
                            if (param_reg == PARAM_SURR)
                            begin
                                used_next[FEAT_SURR] = 1'b1;
                            end
                            else
                            begin
                                used_next[FEAT_PAN] = 1'b1;
                            end
                        end
                        else
                        begin
                            used_next[FEAT_UNKNOWN] = 1'b1;
                        end
                        for (int k = 0; k < EFFECT_SLOTS; k++)
                        begin
                            if (cnt == 4'(k))
                            begin
                                fx_new[k*16 +: 16] = {code_reg, param_reg};
                            end
                        end
                        head_new.flags = (rd_head.flags & ~FLAG_COUNT) | {2'b00, cnt + 4'd1};
                        wr_en    = 1'b1;
                        status_n = ST_STORED;
                    end
                end
            end
            default: ;
        endcase

        // nothing lands unless the result register can take the beat
        if (!fire)
        begin
            wr_en = 1'b0;
        end

        track_next = track_reg;
        if (clr_track)
        begin
            track_next = '0;
            ended_next = 1'b0;
        end
        else if (wr_en)
        begin
            track_next = track_reg | head_new.flags;
        end

        valid_next = valid_reg;
        if (fire && clr_track)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[row_reg[RW-1:0]] = 1'b1;
        end

        head_show = '0;
        fx_show   = '0;
        if (show)
        begin
            head_show = wr_en ? head_new : rd_head;
            fx_show   = wr_en ? fx_new : rd_fx;
        end

        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            track_reg     <= '0;
            ended_reg     <= 1'b0;
            used_reg      <= '0;
            max_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                track_reg <= track_next;
                ended_reg <= ended_next;
                used_reg  <= used_next;
                max_reg   <= max_next;
            end
        end
    end

    // beat capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= evt.command;
            row_reg      <= evt.row;
            code_reg     <= evt.code;
            param_reg    <= evt.param;
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (fire)
        begin
            status_reg    <= status_n;
            row_out_reg   <= show ? row_reg[5:0] : 6'd0;
            head_out_reg  <= head_show;
            fx_out_reg    <= 64'(fx_show);
            track_out_reg <= track_next;
            feat_out_reg  <= feature_view(used_next, max_next);
            max_out_reg   <= max_next;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.status          = status_reg;
    assign res.row_out         = row_out_reg;
    assign res.note            = head_out_reg.note;
    assign res.volume          = head_out_reg.volume;
    assign res.sample          = head_out_reg.sample;
    assign res.event_flags     = head_out_reg.flags;
    assign res.effects         = fx_out_reg;
    assign res.track_flags     = track_out_reg;
    assign res.feature_mask    = feat_out_reg;
    assign res.highest_effects = max_out_reg;

endmodule

`default_nettype wire
